@@ rtl/sialu_pkg.sv @@
// ============================================================================
// sialu_pkg: shared types and constants of the signed integer unit
// Operation codes, the data width and the result record used by the core
// and by the top level.
// ============================================================================
package sialu_pkg;

	// Data width of the operands and of the result.
	localparam int DATA_W  = 32;
	// Index of the sign bit.
	localparam int TOP_BIT = 31;
	// Width of the operation code.
	localparam int CMD_W   = 3;
	// Width of the iteration counter, which indexes the bits of a word.
	localparam int CNT_W   = $clog2(DATA_W);

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [DATA_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam cmd_t CMD_ADD = 3'd0;
	localparam cmd_t CMD_SUB = 3'd1;
	localparam cmd_t CMD_MUL = 3'd2;
	localparam cmd_t CMD_DIV = 3'd3;
	localparam cmd_t CMD_REM = 3'd4;

	// One finished result.
	typedef struct packed {
		word_t result;
		logic  dz;
	} res_t;

endpackage

@@ rtl/sialu_addsub.sv @@
// ============================================================================
// sialu_addsub: shared adder and subtractor
// One 33-bit add or subtract; bit 32 of a subtraction of zero-extended
// values is the borrow.
// ============================================================================
module sialu_addsub
	import sialu_pkg::*;
(
	input  logic [DATA_W:0] x,
	input  logic [DATA_W:0] y,
	input  logic            sub,
	output logic [DATA_W:0] sum
);

	logic [DATA_W:0] y_inv;

	assign y_inv = sub ? ~y : y;
	assign sum   = x + y_inv + {{DATA_W{1'b0}}, sub};

endmodule

@@ rtl/sialu_core.sv @@
// ============================================================================
// sialu_core: sequencer and registers of the signed integer unit
// Runs add and subtract in one pass and multiply, divide and remainder as
// one bit per cycle through a single shared adder.
// ============================================================================
module sialu_core
	import sialu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  cmd_t  cmd,
	input  word_t a,
	input  word_t b,
	output logic  ready,
	output logic  res_valid,
	input  logic  take,
	output res_t  res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ABS_A = 3'd1;
	localparam logic [2:0] ST_ABS_B = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_FIX   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]      state_q;
	cmd_t            cmd_q;
	word_t           a_q;
	word_t           b_q;
	word_t           acc_q;
	cnt_t            cnt_q;
	logic            neg_q;
	res_t            res_q;

	logic [DATA_W:0] add_x;
	logic [DATA_W:0] add_y;
	logic            add_sub;
	logic [DATA_W:0] add_sum;
	word_t           rem_shift;
	logic            is_div;

	assign is_div    = (cmd_q == CMD_DIV) || (cmd_q == CMD_REM);
	// Partial remainder with the next dividend bit shifted in.
	assign rem_shift = {acc_q[DATA_W-2:0], a_q[TOP_BIT]};

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (state_q)
			ST_IDLE: begin
				add_x   = {1'b0, a};
				add_y   = {1'b0, b};
				add_sub = (cmd == CMD_SUB);
			end
			ST_ABS_A: begin
				add_y   = {1'b0, a_q};
				add_sub = a_q[TOP_BIT];
			end
			ST_ABS_B: begin
				add_y   = {1'b0, b_q};
				add_sub = b_q[TOP_BIT];
			end
			ST_RUN: begin
				if (is_div) begin
					add_x   = {1'b0, rem_shift};
					add_y   = {1'b0, b_q};
					add_sub = 1'b1;
				end else begin
					add_x   = {1'b0, acc_q};
					add_y   = {1'b0, a_q};
				end
			end
			ST_FIX: begin
				add_y   = (cmd_q == CMD_DIV) ? {1'b0, a_q} : {1'b0, acc_q};
				add_sub = neg_q;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	sialu_addsub u_addsub (
		.x   (add_x),
		.y   (add_y),
		.sub (add_sub),
		.sum (add_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (cmd == CMD_MUL ||
						    ((cmd == CMD_DIV || cmd == CMD_REM) && b != '0)) begin
							state_q <= ST_ABS_A;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_ABS_A: state_q <= ST_ABS_B;
				ST_ABS_B: state_q <= ST_RUN;
				ST_RUN: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: state_q <= ST_DONE;
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q <= cmd;
					a_q   <= a;
					b_q   <= b;
					acc_q <= '0;
					cnt_q <= cnt_t'(TOP_BIT);
					neg_q <= (cmd == CMD_REM) ? a[TOP_BIT] : (a[TOP_BIT] ^ b[TOP_BIT]);
					if (cmd == CMD_ADD || cmd == CMD_SUB) begin
						res_q.dz     <= 1'b0;
						res_q.result <= add_sum[DATA_W-1:0];
					end else if ((cmd == CMD_DIV || cmd == CMD_REM) && b == '0) begin
						res_q.dz     <= 1'b1;
						res_q.result <= (cmd == CMD_DIV) ? '1 : a;
					end else begin
						res_q.dz     <= 1'b0;
						res_q.result <= '0;
					end
				end
			end
			ST_ABS_A: a_q <= add_sum[DATA_W-1:0];
			ST_ABS_B: b_q <= add_sum[DATA_W-1:0];
			ST_RUN: begin
				cnt_q <= cnt_q - 1'b1;
				if (is_div) begin
					// Restoring step: keep the difference unless it borrowed.
					acc_q <= add_sum[DATA_W] ? rem_shift : add_sum[DATA_W-1:0];
					a_q   <= {a_q[DATA_W-2:0], ~add_sum[DATA_W]};
				end else begin
					if (b_q[0]) begin
						acc_q <= add_sum[DATA_W-1:0];
					end
					a_q <= {a_q[DATA_W-2:0], 1'b0};
					b_q <= {1'b0, b_q[DATA_W-1:1]};
				end
			end
			ST_FIX: begin
				res_q.result <= add_sum[DATA_W-1:0];
				res_q.dz     <= 1'b0;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign ready     = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

`ifndef SYNTHESIS
	// The last iteration always hands over to the sign fix-up.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == '0) |=> (state_q == ST_FIX))
		else $error("iteration did not end after the last bit");

	// The zero-divisor flag is only ever raised for divide or remainder.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.dz) |-> (cmd_q == CMD_DIV || cmd_q == CMD_REM))
		else $error("divide-by-zero flag on a non-division request");

	// A new request never starts while a result is still pending in the core.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !take) |=> (res_valid && !ready))
		else $error("pending result dropped");

	// Division work only runs with a nonzero divisor magnitude.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && is_div) |-> (b_q != '0))
		else $error("division iterating with a zero divisor");
`endif

endmodule

@@ rtl/signed_integer_alu_mul_div_unit.sv @@
// ============================================================================
// signed_integer_alu_mul_div_unit: 32-bit signed add, subtract, multiply,
// divide and remainder
// Top level with the request and result stream ports and the output
// register.
// ============================================================================
//
// Usage:
//   A request enters on the s_axis channel: s_axis_tuser carries the
//   operation (0 add, 1 subtract, 2 multiply, 3 divide, 4 remainder) and
//   s_axis_tdata the two signed operands. Each request gives exactly one
//   result on the m_axis channel: m_axis_tdata holds the 32-bit wrapped
//   result and m_axis_tuser the divide-by-zero flag.
//   Add, subtract, a zero divisor and unused codes are registered in the core
//   on acceptance and then move into the output register. Multiply, divide
//   and remainder first take the operand magnitudes, then work one bit per
//   step through the single shared 33-bit adder, then fix up the sign and
//   then move into the output register.
//   One request is in work at a time; s_axis_tready rises again once the
//   result has moved to the output register, so a new request can be taken
//   while the previous result still waits there.
//   If the receiver stalls, the result stays in the output register and the
//   finished next one waits inside the core; no further request is taken.
//   Reset clears the sequencer and the output valid; the block comes out
//   of reset ready and with no result pending.
//
module signed_integer_alu_mul_div_unit
	import sialu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [2*DATA_W-1:0] s_axis_tdata,  // operand_a [31:0], operand_b [63:32]
	input  cmd_t                s_axis_tuser,  // cmd [2:0]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output word_t               m_axis_tdata,  // result [31:0]
	output logic                m_axis_tuser   // divide_by_zero [0]
);

	logic core_ready;
	logic core_valid;
	logic core_take;
	res_t core_res;
	logic out_valid_q;
	res_t out_q;

	// The core finishes into the output register whenever that register is
	// empty or is being emptied in the same cycle.
	assign core_take = core_valid && (!out_valid_q || m_axis_tready);

	sialu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_axis_tvalid && core_ready),
		.cmd       (s_axis_tuser),
		.a         (s_axis_tdata[DATA_W-1:0]),
		.b         (s_axis_tdata[2*DATA_W-1:DATA_W]),
		.ready     (core_ready),
		.res_valid (core_valid),
		.take      (core_take),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_take) begin
			out_q <= core_res;
		end
	end

	assign s_axis_tready = core_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.result;
	assign m_axis_tuser  = out_q.dz;

endmodule

@@ bench/signed_integer_alu_mul_div_unit_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// signed_integer_alu_mul_div_unit_test: self-checking bench of the integer unit
// Requests drive add, subtract, multiply, divide and remainder through the
// stream ports. Each accepted request is predicted in the bench, and every
// result is checked against the oldest prediction. Both sides idle at random,
// and one phase holds the result side off long enough to back up the unit.
// ============================================================================
module signed_integer_alu_mul_div_unit_test;
	import sialu_pkg::*;

	// Operation codes the unit does not define; they must give zero and no flag.
	localparam cmd_t CMD_SPARE_LO = 3'd5;
	localparam cmd_t CMD_SPARE_HI = 3'd7;
	localparam int   NUM_OPS      = 5;

	// Corner operand values.
	localparam word_t MOST_NEG  = 32'h8000_0000;
	localparam word_t MOST_POS  = 32'h7fff_ffff;
	localparam word_t MINUS_ONE = 32'hffff_ffff;
	localparam word_t ZERO      = 32'h0000_0000;
	localparam word_t ONE       = 32'h0000_0001;

	// The drain wait outlasts the slowest request from acceptance to a valid result.
	localparam int DRAIN_CYCLES = 40;
	// Cycles with no handshake on either side before the run is declared hung.
	// The long result hold-off phase stays well below this.
	localparam int HANG_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_MAX     = 12;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [2*DATA_W-1:0] s_axis_tdata;  // operand_a [31:0], operand_b [63:32]
	cmd_t                s_axis_tuser;  // cmd [2:0]
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	word_t               m_axis_tdata;  // result [31:0]
	logic                m_axis_tuser;  // divide_by_zero [0]

	// Results predicted for accepted requests, oldest first.
	res_t pending_results[$];
	int   mismatches = 0;

	// Idling controls of the request side and of the result side.
	int request_gap_max  = IDLE_MAX;
	int result_stall_max = IDLE_MAX;
	// A nonzero value makes the result side stall that long once.
	int hold_off_request = 0;

	signed_integer_alu_mul_div_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Computes what the unit must return for one request. Multiply forms the
	// product of the magnitudes by shift and add, then fixes the sign. Divide and
	// remainder run a restoring division on the magnitudes; the quotient is
	// negated when the signs differ and the remainder follows the dividend.
	function automatic res_t alu_outcome(input cmd_t op, input word_t a, input word_t b);
		res_t            r;
		word_t           mag_a;
		word_t           mag_b;
		word_t           acc;
		word_t           quo;
		logic [DATA_W:0] part;
		int              i;
		r.result = ZERO;
		r.dz     = 1'b0;
		mag_a    = a[TOP_BIT] ? -a : a;
		mag_b    = b[TOP_BIT] ? -b : b;
		case (op)
			CMD_ADD: begin
				r.result = a + b;
			end
			CMD_SUB: begin
				r.result = a - b;
			end
			CMD_MUL: begin
				acc = ZERO;
				for (i = 0; i <= TOP_BIT; i++) begin
					if (mag_b[i])
						acc = acc + (mag_a << i);
				end
				r.result = (a[TOP_BIT] ^ b[TOP_BIT]) ? -acc : acc;
			end
			CMD_DIV, CMD_REM: begin
				if (b == ZERO) begin
					// A zero divisor raises the flag; divide gives all ones and
					// remainder passes the dividend through.
					r.dz     = 1'b1;
					r.result = (op == CMD_DIV) ? MINUS_ONE : a;
				end else begin
					part = '0;
					quo  = ZERO;
					for (i = TOP_BIT; i >= 0; i--) begin
						part = {part[DATA_W-1:0], mag_a[i]};
						if (part >= {1'b0, mag_b}) begin
							part   = part - {1'b0, mag_b};
							quo[i] = 1'b1;
						end
					end
					if (op == CMD_DIV)
						r.result = (a[TOP_BIT] != b[TOP_BIT]) ? -quo : quo;
					else
						r.result = a[TOP_BIT] ? -part[DATA_W-1:0] : part[DATA_W-1:0];
				end
			end
			default: begin
				r.result = ZERO;
			end
		endcase
		return r;
	endfunction

	// Draws an operand biased toward the corners: the extremes, zero, plus and
	// minus one, small values, values of random bit length and fully random ones.
	function automatic word_t random_operand();
		word_t v;
		case ($urandom_range(0, 9))
			0: v = MOST_NEG;
			1: v = MOST_POS;
			2: v = ZERO;
			3: v = ONE;
			4: v = MINUS_ONE;
			5: begin
				v = $urandom_range(0, 40);
				if ($urandom_range(0, 1))
					v = -v;
			end
			6: begin
				v = $urandom >> $urandom_range(0, TOP_BIT);
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Mostly the five defined operations, now and then a spare code.
	function automatic cmd_t random_op();
		int pick;
		pick = $urandom_range(0, 39);
		if (pick < 38)
			return cmd_t'(CMD_ADD + pick % NUM_OPS);
		return cmd_t'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
	endfunction

	// Offers one request after a random gap and waits for it to be taken. With
	// no gap the valid stays high from the previous request, so it is never
	// lowered and raised again in the same step.
	task automatic issue_request(input cmd_t op, input word_t a, input word_t b);
		int gap;
		gap = $urandom_range(0, request_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(alu_outcome(op, a, b));
	endtask

	task automatic issue_random_request();
		issue_request(random_op(), random_operand(), random_operand());
	endtask

	// Directed corners: wrap-around of add and subtract, products at the
	// extremes, truncation and remainder signs, zero divisors, the most negative
	// dividend over minus one, and every spare operation code.
	task automatic test_corner_cases();
		issue_request(CMD_ADD, MOST_POS, ONE);
		issue_request(CMD_ADD, MOST_NEG, MOST_NEG);
		issue_request(CMD_ADD, MINUS_ONE, ONE);
		issue_request(CMD_SUB, MOST_NEG, ONE);
		issue_request(CMD_SUB, ZERO, MOST_NEG);
		issue_request(CMD_SUB, MOST_POS, MINUS_ONE);
		issue_request(CMD_MUL, MOST_NEG, MINUS_ONE);
		issue_request(CMD_MUL, MOST_POS, MOST_POS);
		issue_request(CMD_MUL, MINUS_ONE, MINUS_ONE);
		issue_request(CMD_MUL, MOST_NEG, MOST_NEG);
		issue_request(CMD_MUL, ZERO, MOST_POS);
		issue_request(CMD_MUL, -word_t'(7), word_t'(3));
		issue_request(CMD_DIV, MOST_NEG, MINUS_ONE);
		issue_request(CMD_REM, MOST_NEG, MINUS_ONE);
		issue_request(CMD_DIV, MOST_POS, ZERO);
		issue_request(CMD_DIV, MOST_NEG, ZERO);
		issue_request(CMD_REM, -word_t'(5), ZERO);
		issue_request(CMD_DIV, -word_t'(7), word_t'(2));
		issue_request(CMD_REM, -word_t'(7), word_t'(2));
		issue_request(CMD_REM, word_t'(7), -word_t'(2));
		issue_request(CMD_DIV, MOST_POS, MOST_NEG);
		issue_request(CMD_DIV, MOST_NEG, MOST_NEG);
		issue_request(CMD_DIV, ZERO, word_t'(5));
		for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
			issue_request(cmd_t'(c), MINUS_ONE, MOST_NEG);
	endtask

	// Requests and results at full rate with no idling on either side.
	task automatic test_full_rate();
		request_gap_max  = 0;
		result_stall_max = 0;
		repeat (300) issue_random_request();
		request_gap_max  = IDLE_MAX;
		result_stall_max = IDLE_MAX;
	endtask

	// The result side stops for a long stretch while requests keep coming, so
	// the output register and the core both fill and the request side stalls.
	task automatic test_result_backpressure();
		request_gap_max  = 0;
		hold_off_request = HOLD_CYCLES;
		repeat (30) issue_random_request();
		request_gap_max  = IDLE_MAX;
	endtask

	// The bulk of the random requests, in phases that change which side idles.
	task automatic test_random_traffic();
		int request_gaps[5] = '{IDLE_MAX, 0, IDLE_MAX, 0, 3};
		int result_gaps[5]  = '{IDLE_MAX, IDLE_MAX, 0, 0, 3};
		for (int phase = 0; phase < 13; phase++) begin
			request_gap_max  = request_gaps[phase % 5];
			result_stall_max = result_gaps[phase % 5];
			repeat (100) issue_random_request();
		end
		request_gap_max  = IDLE_MAX;
		result_stall_max = IDLE_MAX;
	endtask

	// Result side: draws a stall before each result, or takes the one long
	// hold-off when a test has asked for it, then waits for the handshake.
	initial begin : drain_results
		int wait_cycles;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_request > 0) begin
				wait_cycles      = hold_off_request;
				hold_off_request = 0;
			end else begin
				wait_cycles = $urandom_range(0, result_stall_max);
			end
			if (wait_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_axis_tvalid);
		end
	end

	// Every result taken is compared with the oldest prediction.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: result %h, divide_by_zero %b",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata !== want.result) begin
					$error("result mismatch: expected %h, got %h", want.result, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tuser !== want.dz) begin
					$error("divide_by_zero mismatch: expected %b, got %b",
						want.dz, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	// Ends the run when neither side has moved for too long.
	initial begin : hang_watch
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("signed_integer_alu_mul_div_unit verification failed");
		$finish;
	end

	initial begin
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_ADD;
		arst_n        <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_full_rate();
		test_result_backpressure();
		test_random_traffic();
		s_axis_tvalid <= 1'b0;

		// Let every outstanding request finish, then watch a little longer for
		// stray results.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("signed_integer_alu_mul_div_unit verification clean");
		else
			$display("signed_integer_alu_mul_div_unit verification failed");
		$finish;
	end

endmodule

@@ signed_integer_alu_mul_div_unit.f @@
rtl/sialu_pkg.sv
rtl/sialu_addsub.sv
rtl/sialu_core.sv
rtl/signed_integer_alu_mul_div_unit.sv
bench/signed_integer_alu_mul_div_unit_test.sv
